@@ rtl/ptrq_pkg.sv @@
// Shared types and constants of the periodic task ready queue.
// No dependencies; used by every module in rtl/.
package ptrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TASK_COUNT  = 8;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEVEL_W     = 5;
  localparam int TIDX_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [2:0] ACT_TICK       = 3'd0;
  localparam logic [2:0] ACT_ADD        = 3'd1;
  localparam logic [2:0] ACT_ADD_UNIQUE = 3'd2;
  localparam logic [2:0] ACT_GET        = 3'd3;
  localparam logic [2:0] ACT_INIT       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd5;

  typedef logic [QIDX_W-1:0] qidx_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] task_ident;
  } req_t;

  typedef struct packed {
    logic               got_task;
    logic [7:0]         task_out;
    logic [LEVEL_W-1:0] queue_level;
    logic [15:0]        overrun_total;
  } res_t;

endpackage

@@ rtl/ptrq_ring.sv @@
// Ready ring storage: one write port, one read port, registered read data.
// Depends on ptrq_pkg.
module ptrq_ring (
  input  logic            clk,
  input  logic            we,
  input  ptrq_pkg::qidx_t waddr,
  input  logic [7:0]      wdata,
  input  ptrq_pkg::qidx_t raddr,
  output logic [7:0]      rdata
);

  logic [7:0] mem [ptrq_pkg::QUEUE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/periodic_task_ready_queue_unit.sv @@
// Periodic task ready queue, top level.
// Depends on ptrq_pkg and ptrq_ring.

// A request is taken when start is high and busy is low; exactly one result
// comes back per request, on out_res for a single cycle with out_valid high,
// and the receiver cannot hold it off. Timing is set by the serial walk over
// the two memories (ready ring, task counters), one access per cycle: add
// and undefined actions, and get on an empty queue, finish on accept; get
// otherwise reads the ring head first; init writes one counter per task
// after the accept; tick reads, then modifies and writes, the counter of
// each periodic task and skips each task whose mask bit is clear; add-unique
// compares the queued entries in turn, up to QUEUE_DEPTH, until a match.
// The result appears the cycle after the last step and busy drops
// at the same time. No clearing pass after reset.
module periodic_task_ready_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ptrq_pkg::req_t                      in_req,
  output logic                                out_valid,
  output ptrq_pkg::res_t                      out_res,
  input  logic                                cfg_we,
  input  logic [ptrq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptrq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_TICK_RD  = 3'd1;
  localparam logic [2:0] S_TICK_MOD = 3'd2;
  localparam logic [2:0] S_INIT     = 3'd3;
  localparam logic [2:0] S_SRCH     = 3'd4;
  localparam logic [2:0] S_GET      = 3'd5;

  localparam logic [ptrq_pkg::TIDX_W-1:0] LAST_TASK =
    ptrq_pkg::TIDX_W'(ptrq_pkg::TASK_COUNT - 1);
  localparam ptrq_pkg::qidx_t LAST_QIDX = ptrq_pkg::QIDX_W'(ptrq_pkg::QUEUE_DEPTH - 1);
  localparam logic [ptrq_pkg::LEVEL_W-1:0] FULL_LEVEL =
    ptrq_pkg::LEVEL_W'(ptrq_pkg::QUEUE_DEPTH);

  // configuration
  logic [63:0] period_lo_r, period_hi_r, offset_lo_r, offset_hi_r;
  logic [7:0]  mask_r;
  logic [15:0] step_r;

  // control state
  logic [2:0]                        state_r, state_nxt;
  ptrq_pkg::req_t                    req_r;
  logic [ptrq_pkg::TIDX_W-1:0]       idx_r, idx_nxt;
  ptrq_pkg::qidx_t                   pos_r, pos_nxt;
  logic [ptrq_pkg::LEVEL_W-1:0]      k_r, k_nxt;
  ptrq_pkg::qidx_t                   head_r, head_nxt, tail_r, tail_nxt;
  logic [ptrq_pkg::LEVEL_W-1:0]      count_r, count_nxt;
  logic [15:0]                       ovr_r, ovr_nxt;
  logic                              out_valid_r;
  ptrq_pkg::res_t                    out_res_r;

  // counter memory, valid bit per entry stands in for the zero reset
  logic [15:0]                       cnt_mem [ptrq_pkg::TASK_COUNT];
  logic [15:0]                       cnt_rdata_r;
  logic [ptrq_pkg::TASK_COUNT-1:0]   cnt_vld_r;
  logic                              cnt_we;
  logic [15:0]                       cnt_wdata;

  // ring port signals
  logic                              ring_we;
  ptrq_pkg::qidx_t                   ring_raddr;
  logic [7:0]                        ring_wdata;
  logic [7:0]                        ring_rdata;

  // step control
  logic                              emit, got;
  logic [7:0]                        task_o;
  logic                              enq;
  logic [7:0]                        enq_id;
  logic                              init_q;

  // per-task operands
  logic [15:0]                       per_cur, off_cur, cnt_cur;
  logic [16:0]                       cnt_sum;

  function automatic logic [15:0] field16(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [ptrq_pkg::TIDX_W-1:0] t);
    logic [63:0] w;
    w = t[2] ? hi : lo;
    return w[16*t[1:0] +: 16];
  endfunction

  function automatic ptrq_pkg::qidx_t qinc(input ptrq_pkg::qidx_t p);
    return (p == LAST_QIDX) ? '0 : p + 1'b1;
  endfunction

  assign per_cur = field16(period_lo_r, period_hi_r, idx_r);
  assign off_cur = field16(offset_lo_r, offset_hi_r, idx_r);
  assign cnt_cur = cnt_vld_r[idx_r] ? cnt_rdata_r : 16'd0;
  assign cnt_sum = {1'b0, cnt_cur} + {1'b0, step_r};

  ptrq_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (tail_r),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    k_nxt      = k_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    ovr_nxt    = ovr_r;
    ring_we    = 1'b0;
    ring_wdata = 8'd0;
    ring_raddr = head_r;
    cnt_we     = 1'b0;
    cnt_wdata  = 16'd0;
    emit       = 1'b0;
    got        = 1'b0;
    task_o     = 8'd0;
    enq        = 1'b0;
    enq_id     = 8'd0;
    init_q     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // ring read at head is always in flight here, for get and search
        if (start) begin
          unique case (in_req.action)
            ptrq_pkg::ACT_TICK: begin
              idx_nxt   = '0;
              state_nxt = S_TICK_RD;
            end
            ptrq_pkg::ACT_ADD: begin
              enq    = 1'b1;
              enq_id = in_req.task_ident;
              emit   = 1'b1;
            end
            ptrq_pkg::ACT_ADD_UNIQUE: begin
              if (count_r == '0) begin
                enq    = 1'b1;
                enq_id = in_req.task_ident;
                emit   = 1'b1;
              end else begin
                pos_nxt   = head_r;
                k_nxt     = '0;
                state_nxt = S_SRCH;
              end
            end
            ptrq_pkg::ACT_GET: begin
              if (count_r == '0) begin
                emit = 1'b1;
              end else begin
                state_nxt = S_GET;
              end
            end
            ptrq_pkg::ACT_INIT: begin
              init_q    = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_INIT;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_TICK_RD: begin
        // counter read at idx_r issues this cycle; tasks with a clear mask bit are skipped
        if (mask_r[idx_r]) begin
          state_nxt = S_TICK_MOD;
        end else if (idx_r == LAST_TASK) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK_MOD: begin
        cnt_we = 1'b1;
        if (cnt_cur >= per_cur) begin
          enq       = 1'b1;
          enq_id    = 8'(idx_r);
          cnt_wdata = 16'd0;
        end else begin
          cnt_wdata = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
        end
        if (idx_r == LAST_TASK) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TICK_RD;
        end
      end
      S_INIT: begin
        cnt_we    = 1'b1;
        cnt_wdata = per_cur - off_cur;
        if (idx_r == LAST_TASK) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SRCH: begin
        // ring_rdata holds the entry at pos_r
        if (ring_rdata == req_r.task_ident) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (k_r == count_r - 1'b1) begin
          enq       = 1'b1;
          enq_id    = req_r.task_ident;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ring_raddr = qinc(pos_r);
          pos_nxt    = qinc(pos_r);
          k_nxt      = k_r + 1'b1;
        end
      end
      S_GET: begin
        got       = 1'b1;
        task_o    = ring_rdata;
        head_nxt  = qinc(head_r);
        count_nxt = count_r - 1'b1;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (enq) begin
      if (count_r < FULL_LEVEL) begin
        ring_we    = 1'b1;
        ring_wdata = enq_id;
        count_nxt  = count_r + 1'b1;
        tail_nxt   = qinc(tail_r);
      end else if (ovr_r != 16'hFFFF) begin
        ovr_nxt = ovr_r + 1'b1;
      end
    end

    if (init_q) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      ovr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ovr_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_vld_r   <= '0;
      period_lo_r <= '0;
      period_hi_r <= '0;
      offset_lo_r <= '0;
      offset_hi_r <= '0;
      mask_r      <= '0;
      step_r      <= 16'd10;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ovr_r       <= ovr_nxt;
      out_valid_r <= emit;
      if (cnt_we) begin
        cnt_vld_r[idx_r] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ptrq_pkg::REG_PERIOD_LO: period_lo_r <= cfg_wdata;
          ptrq_pkg::REG_PERIOD_HI: period_hi_r <= cfg_wdata;
          ptrq_pkg::REG_OFFSET_LO: offset_lo_r <= cfg_wdata;
          ptrq_pkg::REG_OFFSET_HI: offset_hi_r <= cfg_wdata;
          ptrq_pkg::REG_MASK:      mask_r      <= cfg_wdata[7:0];
          ptrq_pkg::REG_STEP:      step_r      <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers and counter memory
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req;
    end
    if (emit) begin
      out_res_r.got_task      <= got;
      out_res_r.task_out      <= task_o;
      out_res_r.queue_level   <= count_nxt;
      out_res_r.overrun_total <= ovr_nxt;
    end
    if (cnt_we) begin
      cnt_mem[idx_r] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[idx_r];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ tb/periodic_task_ready_queue_unit_tb.sv @@
// Self-checking testbench for periodic_task_ready_queue_unit: directed table, overrun run
// and randomized phases, scored against typed results or a cycle-free shadow of the ready queue.
// Depends on ptrq_pkg and the RTL top level only.
module periodic_task_ready_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptrq_pkg::*;

  // Action codes the block leaves undefined (they must change nothing)
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  localparam int RESET_CYCLES    = 5;
  localparam int SETTLE_CYCLES   = 4;   // extra idle clocks once every result is back
  localparam int END_CYCLES      = 40;
  localparam int STALL_LIMIT     = 5000;
  localparam int PHASE_COUNT     = 6;
  localparam int ITEMS_PER_PHASE = 280;
  localparam int OVERRUN_TICKS   = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  res_t out_res;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  periodic_task_ready_queue_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Shadow copy of the queue, counters and registers
  // ------------------------------------------------------------------
  logic [7:0]         shadow_ring [QUEUE_DEPTH];
  qidx_t              shadow_head;
  qidx_t              shadow_tail;
  logic [LEVEL_W-1:0] shadow_count;
  logic [15:0]        shadow_overruns;
  logic [15:0]        shadow_counters [TASK_COUNT];
  logic [63:0]        shadow_period_lo, shadow_period_hi;
  logic [63:0]        shadow_offset_lo, shadow_offset_hi;
  logic [7:0]         shadow_mask;
  logic [15:0]        shadow_step;

  res_t awaited_results [$];
  int   error_count = 0;
  int   quiet_cycles = 0;
  res_t oldest_want;

  task automatic report_error(string msg);
    $display("%0t ns  MISMATCH  %s", $time, msg);
    error_count++;
  endtask

  function automatic res_t make_result(logic g, logic [7:0] t, logic [LEVEL_W-1:0] l,
                                       logic [15:0] o);
    res_t r;
    r.got_task      = g;
    r.task_out      = t;
    r.queue_level   = l;
    r.overrun_total = o;
    return r;
  endfunction

  function automatic req_t make_req(logic [2:0] act, logic [7:0] id);
    req_t r;
    r.action     = act;
    r.task_ident = id;
    return r;
  endfunction

  // 16-bit lane of task i out of a low/high register pair
  function automatic logic [15:0] lane16(logic [63:0] lo, logic [63:0] hi, int i);
    logic [63:0] w;
    w = (i < 4) ? lo : hi;
    return w[16*(i%4) +: 16];
  endfunction

  function automatic void clear_shadow();
    shadow_period_lo = '0;
    shadow_period_hi = '0;
    shadow_offset_lo = '0;
    shadow_offset_hi = '0;
    shadow_mask      = '0;
    shadow_step      = 16'd10;
    for (int i = 0; i < QUEUE_DEPTH; i++) shadow_ring[i] = '0;
    shadow_head     = '0;
    shadow_tail     = '0;
    shadow_count    = '0;
    shadow_overruns = '0;
    for (int i = 0; i < TASK_COUNT; i++) shadow_counters[i] = '0;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      REG_PERIOD_LO: shadow_period_lo = val;
      REG_PERIOD_HI: shadow_period_hi = val;
      REG_OFFSET_LO: shadow_offset_lo = val;
      REG_OFFSET_HI: shadow_offset_hi = val;
      REG_MASK:      shadow_mask      = val[7:0];
      REG_STEP:      shadow_step      = val[15:0];
      default: ;
    endcase
  endfunction

  // Full queue drops the id and bumps the saturating overrun count
  function automatic void push_ready(logic [7:0] id);
    if (shadow_count < LEVEL_W'(QUEUE_DEPTH)) begin
      shadow_ring[shadow_tail] = id;
      shadow_count++;
      shadow_tail++;
    end else if (shadow_overruns != 16'hFFFF) begin
      shadow_overruns++;
    end
  endfunction

  function automatic bit already_queued(logic [7:0] id);
    qidx_t pos;
    pos = shadow_head;
    for (int k = 0; k < int'(shadow_count); k++) begin
      if (shadow_ring[pos] == id) return 1'b1;
      pos++;
    end
    return 1'b0;
  endfunction

  // Advances the shadow by one request and returns the result it must produce
  function automatic res_t next_queue_result(req_t r);
    logic        got;
    logic [7:0]  taken;
    logic [15:0] per;
    logic [16:0] sum;
    got   = 1'b0;
    taken = '0;
    case (r.action)
      ACT_TICK: begin
        for (int i = 0; i < TASK_COUNT; i++) begin
          if (shadow_mask[i]) begin
            per = lane16(shadow_period_lo, shadow_period_hi, i);
            if (shadow_counters[i] >= per) begin
              // counter clears even when the enqueue is refused
              push_ready(8'(i));
              shadow_counters[i] = '0;
            end else begin
              sum = {1'b0, shadow_counters[i]} + {1'b0, shadow_step};
              shadow_counters[i] = sum[16] ? 16'hFFFF : sum[15:0];
            end
          end
        end
      end
      ACT_ADD: push_ready(r.task_ident);
      ACT_ADD_UNIQUE: begin
        if (!already_queued(r.task_ident)) push_ready(r.task_ident);
      end
      ACT_GET: begin
        if (shadow_count != 0) begin
          got   = 1'b1;
          taken = shadow_ring[shadow_head];
          shadow_count--;
          shadow_head++;
        end
      end
      ACT_INIT: begin
        shadow_head     = '0;
        shadow_tail     = '0;
        shadow_count    = '0;
        shadow_overruns = '0;
        for (int i = 0; i < TASK_COUNT; i++) begin
          shadow_counters[i] = lane16(shadow_period_lo, shadow_period_hi, i) -
                               lane16(shadow_offset_lo, shadow_offset_hi, i);
        end
      end
      default: ;
    endcase
    return make_result(got, taken, shadow_count, shadow_overruns);
  endfunction

  // ------------------------------------------------------------------
  // Result scoring: every strobe pairs with the oldest awaited result
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (awaited_results.size() == 0) begin
        report_error($sformatf("result %h with no request outstanding", out_res));
      end else begin
        oldest_want = awaited_results.pop_front();
        if (out_res.got_task !== oldest_want.got_task)
          report_error($sformatf("got_task %b, want %b", out_res.got_task,
                                 oldest_want.got_task));
        if (out_res.task_out !== oldest_want.task_out)
          report_error($sformatf("task_out %h, want %h", out_res.task_out,
                                 oldest_want.task_out));
        if (out_res.queue_level !== oldest_want.queue_level)
          report_error($sformatf("queue_level %0d, want %0d", out_res.queue_level,
                                 oldest_want.queue_level));
        if (out_res.overrun_total !== oldest_want.overrun_total)
          report_error($sformatf("overrun_total %0d, want %0d", out_res.overrun_total,
                                 oldest_want.overrun_total));
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------
  // Presents one request and holds it until taken. start is left high, so a
  // back-to-back request just replaces in_req at the acceptance edge.
  task automatic issue_request(req_t r, bit typed, res_t want);
    res_t predicted;
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = next_queue_result(r);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // A zero gap leaves start alone so the next request follows directly
  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result is back
  task automatic settle_idle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_setting(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Ids mostly collide with periodic task ids so add-unique finds matches
  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 32)      r.action = ACT_TICK;
    else if (pick < 47) r.action = ACT_ADD;
    else if (pick < 67) r.action = ACT_ADD_UNIQUE;
    else if (pick < 92) r.action = ACT_GET;
    else if (pick < 95) r.action = ACT_INIT;
    else                r.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    r.task_ident = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                              : 8'($urandom_range(0, 255));
    return r;
  endfunction

  // One register setting per phase; phases 1, 2 and 4 sit on the extremes
  task automatic program_phase(int phase);
    logic [15:0] per [TASK_COUNT];
    logic [15:0] off [TASK_COUNT];
    logic [63:0] plo, phi, olo, ohi;
    logic [7:0]  msk;
    logic [15:0] stp;
    for (int i = 0; i < TASK_COUNT; i++) begin
      case (phase)
        0: begin per[i] = 16'($urandom_range(0, 40)); off[i] = 16'($urandom_range(0, 40)); end
        1: begin per[i] = 16'hFFFF;                   off[i] = 16'($urandom);              end
        2: begin per[i] = 16'h0000;                   off[i] = 16'hFFFF;                   end
        3: begin per[i] = 16'($urandom);              off[i] = 16'($urandom);              end
        4: begin per[i] = 16'($urandom_range(0, 8));  off[i] = 16'($urandom_range(0, 8));  end
        default: begin per[i] = 16'($urandom_range(0, 60)); off[i] = '0; end
      endcase
    end
    case (phase)
      0: begin msk = 8'($urandom); stp = 16'($urandom_range(1, 15)); end
      1: begin msk = 8'hFF;        stp = 16'hFFFF;                   end
      2: begin msk = 8'h00;        stp = 16'd1;                      end
      3: begin msk = 8'($urandom); stp = 16'($urandom);              end
      4: begin msk = 8'hFF;        stp = 16'd0;                      end
      default: begin msk = 8'($urandom); stp = 16'($urandom_range(1, 30)); end
    endcase
    plo = {per[3], per[2], per[1], per[0]};
    phi = {per[7], per[6], per[5], per[4]};
    olo = {off[3], off[2], off[1], off[0]};
    ohi = {off[7], off[6], off[5], off[4]};
    settle_idle();
    write_reg(REG_PERIOD_LO, plo);
    write_reg(REG_PERIOD_HI, phi);
    write_reg(REG_OFFSET_LO, olo);
    write_reg(REG_OFFSET_HI, ohi);
    write_reg(REG_MASK, {56'd0, msk});
    write_reg(REG_STEP, {48'd0, stp});
  endtask

  // ------------------------------------------------------------------
  // Directed table: a row is either a register write or a request; a
  // request row carries a typed-in result only where it is obvious
  // ------------------------------------------------------------------
  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [63:0]          reg_val;
    req_t                 req;
    bit                   typed;
    res_t                 want;
  } plan_row_t;

  plan_row_t directed_plan [$];

  function automatic plan_row_t req_row(logic [2:0] act, logic [7:0] id);
    plan_row_t p;
    p.is_write       = 1'b0;
    p.reg_idx        = '0;
    p.reg_val        = '0;
    p.req.action     = act;
    p.req.task_ident = id;
    p.typed          = 1'b0;
    p.want           = '0;
    return p;
  endfunction

  function automatic plan_row_t typed_row(logic [2:0] act, logic [7:0] id, logic g,
                                          logic [7:0] t, logic [LEVEL_W-1:0] l,
                                          logic [15:0] o);
    plan_row_t p;
    p       = req_row(act, id);
    p.typed = 1'b1;
    p.want  = make_result(g, t, l, o);
    return p;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    plan_row_t p;
    p          = req_row(ACT_TICK, '0);
    p.is_write = 1'b1;
    p.reg_idx  = idx;
    p.reg_val  = val;
    return p;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    clear_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: empty queue, nothing periodic, step 10
    directed_plan.push_back(typed_row(ACT_GET,        8'h00, 1'b0, 8'h00, 5'd0, 16'd0));
    directed_plan.push_back(typed_row(ACT_SPARE_FIRST, 8'hFF, 1'b0, 8'h00, 5'd0, 16'd0));
    directed_plan.push_back(typed_row(ACT_SPARE_LAST, 8'h00, 1'b0, 8'h00, 5'd0, 16'd0));
    directed_plan.push_back(typed_row(ACT_TICK,       8'h00, 1'b0, 8'h00, 5'd0, 16'd0));
    directed_plan.push_back(typed_row(ACT_ADD,        8'h00, 1'b0, 8'h00, 5'd1, 16'd0));
    directed_plan.push_back(typed_row(ACT_ADD,        8'hFF, 1'b0, 8'h00, 5'd2, 16'd0));
    directed_plan.push_back(typed_row(ACT_ADD_UNIQUE, 8'hFF, 1'b0, 8'h00, 5'd2, 16'd0));
    directed_plan.push_back(typed_row(ACT_ADD_UNIQUE, 8'h7F, 1'b0, 8'h00, 5'd3, 16'd0));
    directed_plan.push_back(typed_row(ACT_GET,        8'h00, 1'b1, 8'h00, 5'd2, 16'd0));
    directed_plan.push_back(typed_row(ACT_GET,        8'h00, 1'b1, 8'hFF, 5'd1, 16'd0));
    directed_plan.push_back(typed_row(ACT_GET,        8'h00, 1'b1, 8'h7F, 5'd0, 16'd0));
    directed_plan.push_back(typed_row(ACT_GET,        8'h00, 1'b0, 8'h00, 5'd0, 16'd0));
    // Zero periods on every task: each tick offers all eight ids, refused once the queue is full
    directed_plan.push_back(write_row(REG_PERIOD_LO, 64'h0));
    directed_plan.push_back(write_row(REG_PERIOD_HI, 64'h0));
    directed_plan.push_back(write_row(REG_MASK,      64'hFF));
    directed_plan.push_back(typed_row(ACT_TICK,       8'h00, 1'b0, 8'h00, 5'd8, 16'd0));
    directed_plan.push_back(typed_row(ACT_TICK,       8'h00, 1'b0, 8'h00, 5'd16, 16'd0));
    directed_plan.push_back(typed_row(ACT_TICK,       8'h00, 1'b0, 8'h00, 5'd16, 16'd8));
    directed_plan.push_back(typed_row(ACT_ADD,        8'h55, 1'b0, 8'h00, 5'd16, 16'd9));
    directed_plan.push_back(typed_row(ACT_ADD_UNIQUE, 8'h03, 1'b0, 8'h00, 5'd16, 16'd9));
    directed_plan.push_back(typed_row(ACT_ADD_UNIQUE, 8'hAA, 1'b0, 8'h00, 5'd16, 16'd10));
    directed_plan.push_back(typed_row(ACT_GET,        8'h00, 1'b1, 8'h00, 5'd15, 16'd10));
    directed_plan.push_back(req_row(ACT_ADD_UNIQUE, 8'h00));  // id 0 still queued behind
    directed_plan.push_back(typed_row(ACT_INIT,       8'h00, 1'b0, 8'h00, 5'd0, 16'd0));
    // Largest periods and step: counters saturate, then fire
    directed_plan.push_back(write_row(REG_PERIOD_LO, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_plan.push_back(write_row(REG_PERIOD_HI, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_plan.push_back(write_row(REG_OFFSET_LO, 64'h0001_0001_0001_0001));
    directed_plan.push_back(write_row(REG_OFFSET_HI, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_plan.push_back(write_row(REG_STEP,      64'hFFFF));
    directed_plan.push_back(req_row(ACT_INIT, 8'h00));
    directed_plan.push_back(req_row(ACT_TICK, 8'h00));
    directed_plan.push_back(req_row(ACT_TICK, 8'h00));
    // Zero step: counters short of their period never move
    directed_plan.push_back(write_row(REG_PERIOD_LO, 64'h0003_0003_0003_0003));
    directed_plan.push_back(write_row(REG_OFFSET_LO, 64'h0));
    directed_plan.push_back(write_row(REG_STEP,      64'h0));
    directed_plan.push_back(req_row(ACT_INIT, 8'h00));
    directed_plan.push_back(req_row(ACT_TICK, 8'h00));
    directed_plan.push_back(req_row(ACT_TICK, 8'h00));

    foreach (directed_plan[n]) begin
      if (directed_plan[n].is_write) begin
        settle_idle();
        write_reg(directed_plan[n].reg_idx, directed_plan[n].reg_val);
      end else begin
        idle_gap(pick_gap(1'b0));
        issue_request(directed_plan[n].req, directed_plan[n].typed, directed_plan[n].want);
      end
    end

    // Overrun run: zero periods fill the queue, so every tick after the first two
    // refuses eight more ids, then the other enqueue paths hit the full queue too
    settle_idle();
    write_reg(REG_PERIOD_LO, 64'h0);
    write_reg(REG_PERIOD_HI, 64'h0);
    write_reg(REG_MASK,      64'hFF);
    issue_request(make_req(ACT_INIT, 8'h00), 1'b0, '0);
    repeat (OVERRUN_TICKS) issue_request(make_req(ACT_TICK, 8'h00), 1'b0, '0);
    issue_request(make_req(ACT_TICK, 8'h00), 1'b0, '0);
    issue_request(make_req(ACT_ADD, 8'h5A), 1'b0, '0);
    issue_request(make_req(ACT_ADD_UNIQUE, 8'hC3), 1'b0, '0);
    issue_request(make_req(ACT_GET, 8'h00), 1'b0, '0);

    // Random phases: each opens with an init, the last draws no random idle gaps
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      program_phase(ph);
      issue_request(make_req(ACT_INIT, 8'($urandom)), 1'b0, '0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        idle_gap(pick_gap(ph == PHASE_COUNT - 1));
        issue_request(random_request(), 1'b0, '0);
        if ($urandom_range(0, 99) == 0) settle_idle();
      end
    end

    // Drain, then watch a little longer for stray strobes
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_error($sformatf("%0d results never arrived", awaited_results.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
